[rtl/des_block_cipher_unit_macros.svh]
// Assertion macros for the DES cipher unit.
// No dependencies.
`ifndef DES_BLOCK_CIPHER_UNIT_MACROS_SVH
`define DES_BLOCK_CIPHER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define DES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/des_pkg.sv]
// DES package: payload types, command codes, permutation and S-box functions.
// No dependencies.
package des_pkg;

  typedef enum logic [1:0] {
    CmdEncrypt = 2'd0,
    CmdDecrypt = 2'd1,
    CmdRsvd2   = 2'd2,
    CmdRsvd3   = 2'd3
  } des_cmd_e;

  typedef struct packed {
    logic [63:0] block_in;
    logic [63:0] cipher_key;
    logic [1:0]  command;
  } des_in_t;

  typedef struct packed {
    logic [63:0] block_out;
    logic        bad_mode;
  } des_out_t;

  localparam int unsigned NumRounds = 16;

  // Pipeline word carried between round stages.
  typedef struct packed {
    logic [31:0] lh;
    logic [31:0] rh;
    logic [27:0] c;
    logic [27:0] d;
    logic        dec;
    logic        bad;
  } des_stage_t;

  localparam logic [7:0] IpTab [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [7:0] FpTab [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [7:0] ETab [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [7:0] PTab [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
  localparam logic [7:0] Pc1Tab [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [7:0] Pc2Tab [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  // One-bit rotation rounds; the rest rotate by two.
  localparam logic [15:0] RotOne = 16'b1100_0000_1000_0001;

  localparam logic [3:0] SboxTab [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] s);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = s[64 - int'(IpTab[i])];
    return o;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] s);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = s[64 - int'(FpTab[i])];
    return o;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] s);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) o[55-i] = s[64 - int'(Pc1Tab[i])];
    return o;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] s);
    logic [47:0] o;
    for (int i = 0; i < 48; i++) o[47-i] = s[56 - int'(Pc2Tab[i])];
    return o;
  endfunction

  // Round function: E, key mix, S-boxes, P.
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] o;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(ETab[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = SboxTab[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = s[32 - int'(PTab[i])];
    return o;
  endfunction

endpackage

[rtl/des_block_cipher_unit.sv]
// DES cipher unit top level: sixteen-round pipeline with output skid stage.
// Depends on des_pkg and des_block_cipher_unit_macros.svh.
//
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_data_i) carries a block, a key and a
//    command; out channel (out_valid_o/out_ready_i/out_data_o) returns the
//    result block and the bad_mode flag. A transfer is valid and ready high.
//  - One register stage per Feistel round: each stage holds L/R, the key
//    halves C/D and a valid bit. Subkeys are formed on the fly in each stage
//    (encrypt rotates left before the round, decrypt rotates right after).
//  - Input transfer to out_valid_o passes stage 0 (IP, PC-1), 16 round stages
//    and the output register. Throughput: one block per cycle unless stalled.
//  - The round logic (E, S-boxes, P, PC-2) sets the stage depth.
//  - A stall on the out side freezes the whole pipe once a result lands in the
//    skid register; the output and skid registers keep in_ready_o independent
//    of out_ready_i combinational paths, so no transfer is lost or repeated.
//  - Invalid commands travel the pipe flagged and come out as zero with
//    bad_mode set, in order.
//  - Reset clears all valid bits; the pipe is empty afterwards.
`include "des_block_cipher_unit_macros.svh"
module des_block_cipher_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  des_pkg::des_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output des_pkg::des_out_t out_data_o
);
  import des_pkg::*;

  des_stage_t st_q [NumRounds+1];
  logic       vld_q [NumRounds+1];
  des_stage_t st_d [NumRounds+1];
  logic       adv;
  des_out_t   res_d, out_q, skid_q;
  logic       out_vld_q, skid_vld_q;
  logic [55:0] k56;
  logic [63:0] ip_blk;

  // Pipe advances whenever the skid slot is free.
  assign adv        = !skid_vld_q;
  assign in_ready_o = adv;

  // Stage 0 entry: IP and PC-1.
  always_comb begin
    k56    = perm_pc1(in_data_i.cipher_key);
    ip_blk = perm_ip(in_data_i.block_in);
    st_d[0].lh  = ip_blk[63:32];
    st_d[0].rh  = ip_blk[31:0];
    st_d[0].c   = k56[55:28];
    st_d[0].d   = k56[27:0];
    st_d[0].dec = (in_data_i.command == CmdDecrypt);
    st_d[0].bad = (in_data_i.command == CmdRsvd2) || (in_data_i.command == CmdRsvd3);
  end

  // Round r consumes st_q[r] and produces st_d[r+1].
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    logic [27:0] ce, de, cn, dn;
    logic [31:0] f;
    logic        one;
    assign one = RotOne[15-r];
    // Encrypt: rotate left by schedule r. Decrypt round r uses subkey 15-r;
    // starting from K0 state (=rot total 28), rotate right by schedule 15-r
    // after use.
    always_comb begin
      logic one_d;
      one_d = RotOne[r];
      ce = one ? {st_q[r].c[26:0], st_q[r].c[27]} : {st_q[r].c[25:0], st_q[r].c[27:26]};
      de = one ? {st_q[r].d[26:0], st_q[r].d[27]} : {st_q[r].d[25:0], st_q[r].d[27:26]};
      if (st_q[r].dec) begin
        f  = feistel(st_q[r].rh, perm_pc2({st_q[r].c, st_q[r].d}));
        cn = one_d ? {st_q[r].c[0], st_q[r].c[27:1]} : {st_q[r].c[1:0], st_q[r].c[27:2]};
        dn = one_d ? {st_q[r].d[0], st_q[r].d[27:1]} : {st_q[r].d[1:0], st_q[r].d[27:2]};
      end else begin
        f  = feistel(st_q[r].rh, perm_pc2({ce, de}));
        cn = ce;
        dn = de;
      end
      st_d[r+1].c   = cn;
      st_d[r+1].d   = dn;
      st_d[r+1].dec = st_q[r].dec;
      st_d[r+1].bad = st_q[r].bad;
      if (r == NumRounds-1) begin
        st_d[r+1].lh = st_q[r].lh ^ f;
        st_d[r+1].rh = st_q[r].rh;
      end else begin
        st_d[r+1].lh = st_q[r].rh;
        st_d[r+1].rh = st_q[r].lh ^ f;
      end
    end
  end

  // Stage registers; stage 16 feeds the output formatter.
  for (genvar s = 0; s <= NumRounds; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= (s == 0) ? in_valid_i : vld_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) st_q[s] <= st_d[s];
    end
  end

  // Final permutation; invalid command forces zero.
  always_comb begin
    res_d.bad_mode  = st_q[NumRounds].bad;
    res_d.block_out = st_q[NumRounds].bad ? 64'd0
                    : perm_fp({st_q[NumRounds].lh, st_q[NumRounds].rh});
  end

  // Output register with skid slot: while out stalls, one extra result lands
  // in the skid register and the pipe stops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_ready_i || !out_vld_q) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= vld_q[NumRounds];
        end
      end else if (adv && vld_q[NumRounds]) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_vld_q) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (adv) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `DES_ASSERT_IMP(a_skid_needs_out, clk_i, rst_ni, skid_vld_q, out_vld_q)
  `DES_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, out_vld_q && out_q.bad_mode,
                  out_q.block_out == 64'd0)
  `DES_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, out_vld_q && !out_ready_i,
                   out_vld_q && $stable(out_q))

endmodule

[sim/tb_des_block_cipher_unit.sv]
// Testbench for des_block_cipher_unit: directed and random DES blocks checked
// against an in-bench DES predictor. Depends on des_pkg and the RTL top level.
`timescale 1ns / 100ps

// Holds the DES results still owed by the unit, oldest first.
class des_scoreboard;
  des_pkg::des_out_t owed_q[$];
  int unsigned mismatches;
  int unsigned checked;

  static function automatic logic [31:0] round_f(logic [31:0] r, logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] o;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(des_pkg::ETab[i])];
    x ^= k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = des_pkg::SboxTab[i][{six[5], six[0]} * 16 + six[4:1]];
    end
    for (int i = 0; i < 32; i++) o[31-i] = s[32 - int'(des_pkg::PTab[i])];
    return o;
  endfunction

  // Straight single-DES, subkeys reversed for decrypt.
  static function automatic des_pkg::des_out_t cipher(des_pkg::des_in_t t);
    des_pkg::des_out_t res;
    logic [47:0] sub [16];
    logic [55:0] k56;
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [63:0] b, blk;
    logic [31:0] lh, rh, f, tmp;
    int sh;
    if (t.command != des_pkg::CmdEncrypt && t.command != des_pkg::CmdDecrypt) begin
      res.block_out = '0;
      res.bad_mode = 1'b1;
      return res;
    end
    for (int i = 0; i < 56; i++) k56[55-i] = t.cipher_key[64 - int'(des_pkg::Pc1Tab[i])];
    c = k56[55:28];
    d = k56[27:0];
    for (int r = 0; r < 16; r++) begin
      sh = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
      repeat (sh) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) sub[r][47-i] = cd[56 - int'(des_pkg::Pc2Tab[i])];
    end
    for (int i = 0; i < 64; i++) b[63-i] = t.block_in[64 - int'(des_pkg::IpTab[i])];
    lh = b[63:32];
    rh = b[31:0];
    for (int r = 0; r < 16; r++) begin
      f = round_f(rh, sub[(t.command == des_pkg::CmdDecrypt) ? 15 - r : r]);
      if (r != 15) begin
        tmp = rh;
        rh = lh ^ f;
        lh = tmp;
      end else begin
        lh ^= f;
      end
    end
    blk = {lh, rh};
    for (int i = 0; i < 64; i++) res.block_out[63-i] = blk[64 - int'(des_pkg::FpTab[i])];
    res.bad_mode = 1'b0;
    return res;
  endfunction

  function void note_block(des_pkg::des_in_t t);
    owed_q.push_back(cipher(t));
  endfunction

  function void check_block(des_pkg::des_out_t got);
    des_pkg::des_out_t want;
    checked++;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h/%b", got.block_out, got.bad_mode);
      return;
    end
    want = owed_q.pop_front();
    if (got.block_out !== want.block_out || got.bad_mode !== want.bad_mode) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected %h/%b got %h/%b", checked, want.block_out,
                 want.bad_mode, got.block_out, got.bad_mode);
    end
  endfunction
endclass

module tb_des_block_cipher_unit;
  localparam int Latency = 17;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  des_pkg::des_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  des_pkg::des_out_t out_data_o;

  des_scoreboard sb = new();
  int unsigned cycles = 0;
  int send_idle_pct = 0;  // sender gap chance, percent
  int recv_stall_pct = 0; // receiver stall chance, percent
  int hold_cycles = 0;    // long receiver hold-off request
  int unsigned sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  des_block_cipher_unit dut (.*);

  // Output side: sample at rising edge, change ready at the falling edge.
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_valid_o && out_ready_i) sb.check_block(out_data_o);
    if (rst_ni && in_valid_i && in_ready_o) sb.note_block(in_data_i);
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one transfer; valid holds until accepted.
  task automatic send_block(logic [63:0] blk, logic [63:0] key, logic [1:0] cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= '{block_in: blk, cipher_key: key, command: cmd};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    logic [1:0] cmd;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      // Mostly valid commands; invalid ones still need coverage.
      cmd = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
      send_block(pick_word(), pick_word(), cmd);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: known vector, its inverse, extremes and invalid modes.
    send_block(64'h0123456789ABCDEF, 64'h133457799BBCDFF1, des_pkg::CmdEncrypt);
    send_block(64'h85E813540F0AB405, 64'h133457799BBCDFF1, des_pkg::CmdDecrypt);
    send_block('0, '0, des_pkg::CmdEncrypt);
    send_block('1, '1, des_pkg::CmdEncrypt);
    send_block('0, '1, des_pkg::CmdDecrypt);
    send_block('1, '0, des_pkg::CmdDecrypt);
    send_block(64'h0101010101010101, 64'hFEFEFEFEFEFEFEFE, des_pkg::CmdEncrypt);
    send_block(64'h8000000000000000, 64'h0000000000000001, des_pkg::CmdDecrypt);
    send_block('1, '1, des_pkg::CmdRsvd2);
    send_block(64'hDEADBEEFCAFEF00D, 64'h0123456789ABCDEF, des_pkg::CmdRsvd3);
    send_block(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, des_pkg::CmdEncrypt);
    send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, des_pkg::CmdDecrypt);

    random_phase(220, 0, 0);
    random_phase(200, 56, 0);
    random_phase(200, 0, 56);
    // Long hold-off while the sender keeps pushing: pipe fills, input stalls.
    hold_cycles = 60;
    random_phase(60, 0, 0);
    random_phase(160, 6, 6);
    in_valid_i <= 1'b0;
    recv_stall_pct = 20;

    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);

    $display("sent %0d blocks (encrypt, decrypt, invalid modes), checked %0d results",
             sent, sb.checked);
    $display("phases: back-to-back, sender gaps, receiver stalls, both, long hold-off");
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/des_pkg.sv
rtl/des_block_cipher_unit.sv
sim/tb_des_block_cipher_unit.sv
